// ===== src/lir_pkg.sv =====
// lir_pkg: shared constants, types and the rate step table for the
// linear interpolation resampler. No dependencies.
`default_nettype none

package lir_pkg;

    localparam int SEL_BITS  = 3;
    localparam int SEL_MAX   = 5;
    localparam int ROM_FB    = 28;   // fraction bits of the table entries
    localparam int ROM_BITS  = 32;
    localparam int CFG_IDX_BITS = 1;

    // configuration register indexes
    localparam logic [CFG_IDX_BITS-1:0] CFG_SOURCE_RATE = 1'b0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_TARGET_RATE = 1'b1;

    // control from the sequencer to the multiply-add unit
    typedef struct packed {
        logic mul_en;
    } mac_ctrl_t;

    // phase step, source rate over target rate, Q4.28
    localparam logic [ROM_BITS-1:0] STEP_ROM [6][6] = '{
        '{32'h10000000, 32'h116a3b36, 32'h18000000, 32'h20000000, 32'h22d4766c, 32'h30000000},
        '{32'h0eb33333, 32'h10000000, 32'h160ccccd, 32'h1d666666, 32'h20000000, 32'h2c19999a},
        '{32'h0aaaaaab, 32'h0b9c2779, 32'h10000000, 32'h15555555, 32'h17384ef3, 32'h20000000},
        '{32'h08000000, 32'h08b51d9b, 32'h0c000000, 32'h10000000, 32'h116a3b36, 32'h18000000},
        '{32'h0759999a, 32'h08000000, 32'h0b066666, 32'h0eb33333, 32'h10000000, 32'h160ccccd},
        '{32'h05555555, 32'h05ce13bd, 32'h08000000, 32'h0aaaaaab, 32'h0b9c2779, 32'h10000000}
    };

    function automatic logic [SEL_BITS-1:0] sel_sat(input logic [SEL_BITS-1:0] s);
        if (s > SEL_BITS'(SEL_MAX))
            return SEL_BITS'(SEL_MAX);
        return s;
    endfunction

    function automatic logic [ROM_BITS-1:0] step_lookup(
        input logic [SEL_BITS-1:0] src,
        input logic [SEL_BITS-1:0] tgt
    );
        return STEP_ROM[sel_sat(src)][sel_sat(tgt)];
    endfunction

endpackage

`default_nettype wire

// ===== src/lir_mac.sv =====
// lir_mac: shared multiply-add unit, prev + floor(diff * phase / 2^FB).
// Product is registered; the add follows in the next cycle. Uses lir_pkg.
`default_nettype none

module lir_mac #(
    parameter int SAMPLE_BITS   = 32,
    parameter int FRACTION_BITS = 28
) (
    input  wire logic                             clk,
    input  wire lir_pkg::mac_ctrl_t               ctrl,
    input  wire logic signed [SAMPLE_BITS:0]      diff,
    input  wire logic [FRACTION_BITS-1:0]         phase_frac,
    input  wire logic [SAMPLE_BITS-1:0]           prev,
    output logic [SAMPLE_BITS-1:0]                result
);

    localparam int PROD_BITS = SAMPLE_BITS + FRACTION_BITS + 2;

    logic signed [PROD_BITS-1:0] prod_reg;
    logic signed [PROD_BITS-1:0] prod_next;
    logic signed [PROD_BITS-1:0] quot;

    always_comb
    begin
        prod_next = PROD_BITS'(diff) * PROD_BITS'($signed({1'b0, phase_frac}));
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.mul_en)
        begin
            prod_reg <= prod_next;
        end
    end

    // arithmetic shift is floor division; result lies between prev and x
    assign quot   = prod_reg >>> FRACTION_BITS;
    assign result = prev + quot[SAMPLE_BITS-1:0];

endmodule

`default_nettype wire

// ===== src/linear_interp_resampler.sv =====
// sequence: an item is taken in S_IDLE; each result then passes S_MULT and S_ADD in the shared
// multiply-add unit, is registered into the output and is held in S_OUT until taken.
// A run gives n results (0..4) per item, a unity pass-through goes straight to S_OUT, and an
// output stall holds the run; the block takes no item while a run is in progress.
// reset: rst_n clears rate selects, phase, previous sample and primed flag at once.
// Top level of the resampler; depends on lir_pkg and lir_mac.
`default_nettype none

module linear_interp_resampler #(
    parameter int SAMPLE_BITS   = 32,
    parameter int FRACTION_BITS = 28
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_we,
    input  wire logic [lir_pkg::CFG_IDX_BITS-1:0]    cfg_index,
    input  wire logic [lir_pkg::SEL_BITS-1:0]        cfg_data,
    input  wire logic                                in_valid,
    output logic                                     in_stall,
    input  wire logic signed [SAMPLE_BITS-1:0]       sample_in,
    output logic                                     out_valid,
    input  wire logic                                out_stall,
    output logic signed [SAMPLE_BITS-1:0]            sample_out,
    output logic                                     run_last
);

    localparam int PW        = FRACTION_BITS + 3;
    localparam int FB_SHIFT  = lir_pkg::ROM_FB - FRACTION_BITS;
    localparam int SNAP_HALF = 128 >> FB_SHIFT;
    localparam logic [PW-1:0] PHASE_ONE = PW'(1) << FRACTION_BITS;
    localparam logic [PW-1:0] SNAP_ADD  = PW'(SNAP_HALF);
    localparam logic [FRACTION_BITS:0] SNAP_WIN = (FRACTION_BITS+1)'(2 * SNAP_HALF);
    localparam logic [1:0] LAST_CNT = 2'd3;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_MULT = 4'b0010,
        S_ADD  = 4'b0100,
        S_OUT  = 4'b1000
    } state_t;

    state_t                              state_reg, state_next;
    logic [lir_pkg::SEL_BITS-1:0]        src_sel_reg, tgt_sel_reg;
    logic [SAMPLE_BITS-1:0]              prev_reg, prev_next;
    logic [SAMPLE_BITS-1:0]              x_reg;
    logic signed [SAMPLE_BITS:0]         diff_reg;
    logic [PW-1:0]                       phase_reg, phase_next;
    logic                                primed_reg, primed_next;
    logic [1:0]                          cnt_reg, cnt_next;
    logic                                out_valid_reg, out_valid_next;
    logic [SAMPLE_BITS-1:0]              out_data_reg, out_data_next;
    logic                                out_last_reg, out_last_next;

    logic [lir_pkg::ROM_BITS-1:0]        rom_step;
    logic [PW-1:0]                       step;
    logic                                in_beat, out_beat;
    logic [PW-1:0]                       ph_add, ph_bias, ph_new;
    logic                                snap_hit, run_done;
    logic [SAMPLE_BITS-1:0]              mac_result;
    lir_pkg::mac_ctrl_t                  mac_ctrl;

    assign rom_step = lir_pkg::step_lookup(src_sel_reg, tgt_sel_reg);
    assign step     = PW'(rom_step >> FB_SHIFT);

    assign in_stall   = (state_reg != S_IDLE);
    assign in_beat    = in_valid && !in_stall;
    assign out_valid  = out_valid_reg;
    assign out_beat   = out_valid_reg && !out_stall;
    assign sample_out = out_data_reg;
    assign run_last   = out_last_reg;

    // next phase after one result, with snap to a whole number
    always_comb
    begin
        ph_add   = phase_reg + step;
        ph_bias  = ph_add + SNAP_ADD;
        snap_hit = ({1'b0, ph_bias[FRACTION_BITS-1:0]} < SNAP_WIN);
        ph_new   = snap_hit ? {ph_bias[PW-1:FRACTION_BITS], {FRACTION_BITS{1'b0}}} : ph_add;
        run_done = (ph_new >= PHASE_ONE) || (cnt_reg == LAST_CNT);
    end

    assign mac_ctrl.mul_en = (state_reg == S_MULT);

    lir_mac #(
        .SAMPLE_BITS   (SAMPLE_BITS),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_lir_mac (
        .clk        (clk),
        .ctrl       (mac_ctrl),
        .diff       (diff_reg),
        .phase_frac (phase_reg[FRACTION_BITS-1:0]),
        .prev       (prev_reg),
        .result     (mac_result)
    );

    always_comb
    begin
        state_next     = state_reg;
        prev_next      = prev_reg;
        phase_next     = phase_reg;
        primed_next    = primed_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        out_last_next  = out_last_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_beat)
                begin
                    priority if (step == PHASE_ONE)
                    begin
                        // unity ratio: pass through, phase kept
                        out_data_next  = sample_in;
                        out_last_next  = 1'b1;
                        out_valid_next = 1'b1;
                        prev_next      = sample_in;
                        primed_next    = 1'b1;
                        state_next     = S_OUT;
                    end
                    else if (!primed_reg)
                    begin
                        prev_next   = sample_in;
                        primed_next = 1'b1;
                    end
                    else if (phase_reg >= PHASE_ONE)
                    begin
                        // downsampling gap, no result
                        phase_next = phase_reg - PHASE_ONE;
                        prev_next  = sample_in;
                    end
                    else
                    begin
                        cnt_next   = 2'd0;
                        state_next = S_MULT;
                    end
                end
            end
            S_MULT:
            begin
                state_next = S_ADD;
            end
            S_ADD:
            begin
                out_data_next  = mac_result;
                out_last_next  = run_done;
                out_valid_next = 1'b1;
                cnt_next       = cnt_reg + 2'd1;
                if (run_done)
                begin
                    phase_next = (ph_new >= PHASE_ONE) ? ph_new - PHASE_ONE : '0;
                    prev_next  = x_reg;
                end
                else
                begin
                    phase_next = ph_new;
                end
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (out_beat)
                begin
                    out_valid_next = 1'b0;
                    state_next     = out_last_reg ? S_IDLE : S_MULT;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            src_sel_reg   <= '0;
            tgt_sel_reg   <= '0;
            prev_reg      <= '0;
            phase_reg     <= '0;
            primed_reg    <= 1'b0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            prev_reg      <= prev_next;
            phase_reg     <= phase_next;
            primed_reg    <= primed_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    lir_pkg::CFG_SOURCE_RATE: src_sel_reg <= cfg_data;
                    lir_pkg::CFG_TARGET_RATE: tgt_sel_reg <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
        out_last_reg <= out_last_next;
        if (in_beat)
        begin
            x_reg    <= sample_in;
            diff_reg <= $signed({sample_in[SAMPLE_BITS-1], sample_in})
                      - $signed({prev_reg[SAMPLE_BITS-1], prev_reg});
        end
    end

endmodule

`default_nettype wire

// ===== src/lir_checker.sv =====
// lir_port_checks: port-level checks on the resampler, bound to the top level.
// Depends on linear_interp_resampler and lir_pkg.
`default_nettype none

module lir_port_checks #(
    parameter int SAMPLE_BITS   = 32,
    parameter int FRACTION_BITS = 28
) (
    input wire logic                              clk,
    input wire logic                              rst_n,
    input wire logic                              cfg_we,
    input wire logic [lir_pkg::CFG_IDX_BITS-1:0]  cfg_index,
    input wire logic [lir_pkg::SEL_BITS-1:0]      cfg_data,
    input wire logic                              in_valid,
    input wire logic                              in_stall,
    input wire logic [SAMPLE_BITS-1:0]            sample_in,
    input wire logic                              out_valid,
    input wire logic                              out_stall,
    input wire logic [SAMPLE_BITS-1:0]            sample_out,
    input wire logic                              run_last
);

    localparam int FB_CHECK = FRACTION_BITS;

    logic unused_ok;
    assign unused_ok = cfg_we ^ (|cfg_index) ^ (|cfg_data) ^ in_valid ^ (|sample_in)
                     ^ (FB_CHECK > 0);

    // stalled output beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(sample_out) && $stable(run_last))
        else $error("output beat changed while stalled");

    // no new sample taken while a result waits
    a_busy_with_result: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall)
        else $error("input taken while a result is pending");

    // a run that is not finished keeps the input side closed
    a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !run_last |=> in_stall)
        else $error("input opened before the last beat of a run");

    // each result goes out as a single beat, never back to back
    a_single_beat: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall |=> !out_valid)
        else $error("output beats back to back");

endmodule

bind linear_interp_resampler lir_port_checks #(
    .SAMPLE_BITS   (SAMPLE_BITS),
    .FRACTION_BITS (FRACTION_BITS)
) u_lir_checker (.*);

`default_nettype wire

// ===== test/lir_checker.sv =====
// lir_checker: watches the config port and both streams of the linear
// interpolation resampler, predicts every output beat and compares it.
// Depends on lir_pkg for port widths and register indexes.
module lir_checker (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [lir_pkg::CFG_IDX_BITS-1:0]     cfg_index,
    input  logic [lir_pkg::SEL_BITS-1:0]         cfg_data,
    input  logic                                 in_valid,
    input  logic                                 in_stall,
    input  logic signed [31:0]                   sample_in,
    input  logic                                 out_valid,
    input  logic                                 out_stall,
    input  logic signed [31:0]                   sample_out,
    input  logic                                 run_last,
    output int                                   errors,
    output int                                   pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          FRAC_BITS = 28;
    localparam int          MAX_BEATS = 4;
    localparam int          PRINT_CAP = 100;
    localparam logic [31:0] PHASE_ONE = 32'h1000_0000;
    localparam logic [31:0] FRAC_MASK = 32'h0fff_ffff;
    localparam logic [31:0] SNAP_HALF = 32'h0000_0080;

    // source rate over target rate, Q4.28, rows by source select
    localparam logic [31:0] RATE_STEP [6][6] = '{
        '{32'h10000000, 32'h116a3b36, 32'h18000000, 32'h20000000, 32'h22d4766c, 32'h30000000},
        '{32'h0eb33333, 32'h10000000, 32'h160ccccd, 32'h1d666666, 32'h20000000, 32'h2c19999a},
        '{32'h0aaaaaab, 32'h0b9c2779, 32'h10000000, 32'h15555555, 32'h17384ef3, 32'h20000000},
        '{32'h08000000, 32'h08b51d9b, 32'h0c000000, 32'h10000000, 32'h116a3b36, 32'h18000000},
        '{32'h0759999a, 32'h08000000, 32'h0b066666, 32'h0eb33333, 32'h10000000, 32'h160ccccd},
        '{32'h05555555, 32'h05ce13bd, 32'h08000000, 32'h0aaaaaab, 32'h0b9c2779, 32'h10000000}
    };

    typedef struct packed {
        logic signed [31:0] value;
        logic               last;
    } interp_beat_t;

    interp_beat_t                  expected_beats[$];
    logic [lir_pkg::SEL_BITS-1:0]  src_sel;
    logic [lir_pkg::SEL_BITS-1:0]  tgt_sel;
    logic signed [31:0]            prev_sample;
    logic [31:0]                   phase;
    logic                          primed;

    initial
    begin
        errors = 0;
    end

    function automatic int clamp_sel(input logic [lir_pkg::SEL_BITS-1:0] sel);
        return (sel > lir_pkg::SEL_MAX) ? lir_pkg::SEL_MAX : int'(sel);
    endfunction

    task automatic report_mismatch(input string msg);
        if (errors < PRINT_CAP)
        begin
            $display("%0t mismatch: %s", $time, msg);
        end
        errors = errors + 1;
    endtask

    task automatic predict_beats(input logic signed [31:0] x);
        logic [31:0]  step;
        interp_beat_t beat;
        int           n;
        longint       diff;
        longint       prod;
        step = RATE_STEP[clamp_sel(src_sel)][clamp_sel(tgt_sel)];
        n = 0;
        if (step == PHASE_ONE)
        begin
            // pass-through, phase left alone
            beat.value = x;
            beat.last = 1'b1;
            expected_beats.push_back(beat);
            prev_sample = x;
            primed = 1'b1;
        end
        else if (!primed)
        begin
            prev_sample = x;
            primed = 1'b1;
        end
        else
        begin
            while (phase < PHASE_ONE && n < MAX_BEATS)
            begin
                // 33-bit difference, floor of the scaled product
                diff = longint'(x) - longint'(prev_sample);
                prod = diff * longint'(phase);
                beat.value = 32'(longint'(prev_sample) + (prod >>> FRAC_BITS));
                beat.last = 1'b0;
                expected_beats.push_back(beat);
                n++;
                phase = phase + step;
                if (((phase + SNAP_HALF) & FRAC_MASK) < 2 * SNAP_HALF)
                begin
                    phase = (phase + SNAP_HALF) & ~FRAC_MASK;
                end
            end
            if (n > 0)
            begin
                beat = expected_beats.pop_back();
                beat.last = 1'b1;
                expected_beats.push_back(beat);
            end
            if (phase >= PHASE_ONE)
            begin
                phase = phase - PHASE_ONE;
            end
            else
            begin
                phase = '0;
            end
            prev_sample = x;
        end
    endtask

    task automatic check_beat();
        interp_beat_t want;
        if (expected_beats.size() == 0)
        begin
            report_mismatch($sformatf("beat with nothing expected: sample_out=%h run_last=%b",
                                      sample_out, run_last));
            return;
        end
        want = expected_beats.pop_front();
        if (sample_out !== want.value)
        begin
            report_mismatch($sformatf("sample_out=%h, want %h", sample_out, want.value));
        end
        if (run_last !== want.last)
        begin
            report_mismatch($sformatf("run_last=%b, want %b (sample %h)",
                                      run_last, want.last, want.value));
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_sel = '0;
            tgt_sel = '0;
            prev_sample = '0;
            phase = '0;
            primed = 1'b0;
            expected_beats.delete();
            pending <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == lir_pkg::CFG_SOURCE_RATE)
                begin
                    src_sel = cfg_data;
                end
                else if (cfg_index == lir_pkg::CFG_TARGET_RATE)
                begin
                    tgt_sel = cfg_data;
                end
            end
            if (in_valid && !in_stall)
            begin
                predict_beats(sample_in);
            end
            if (out_valid && !out_stall)
            begin
                check_beat();
            end
            pending <= expected_beats.size();
        end
    end

endmodule

// ===== test/linear_interp_resampler_tb.sv =====
// linear_interp_resampler_tb: clock, reset, sample and config stimulus with
// random idling on both streams; checking is done by lir_checker.
// Depends on lir_pkg, lir_checker and the resampler RTL.
module linear_interp_resampler_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          RANDOM_ITEMS   = 345;
    localparam int          SETTLE_CYCLES  = 20;
    localparam int          WATCHDOG_LIMIT = 2000;
    localparam logic [31:0] MAX_SAMPLE     = 32'h7fff_ffff;
    localparam logic [31:0] MIN_SAMPLE     = 32'h8000_0000;

    // rate selects
    localparam logic [2:0] RATE_48000 = 3'd0;
    localparam logic [2:0] RATE_44100 = 3'd1;
    localparam logic [2:0] RATE_32000 = 3'd2;
    localparam logic [2:0] RATE_16000 = 3'd5;
    localparam logic [2:0] RATE_SAT_A = 3'd6;
    localparam logic [2:0] RATE_SAT_B = 3'd7;

    logic                                clk = 1'b0;
    logic                                rst_n;
    logic                                cfg_we;
    logic [lir_pkg::CFG_IDX_BITS-1:0]    cfg_index;
    logic [lir_pkg::SEL_BITS-1:0]        cfg_data;
    logic                                in_valid;
    logic                                in_stall;
    logic signed [31:0]                  sample_in;
    logic                                out_valid;
    logic                                out_stall;
    logic signed [31:0]                  sample_out;
    logic                                run_last;
    int                                  fail_count;
    int                                  pending;
    int                                  quiet_cycles = 0;
    logic                                no_idle;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    linear_interp_resampler u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .sample_in  (sample_in),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .sample_out (sample_out),
        .run_last   (run_last)
    );

    lir_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .sample_in  (sample_in),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .sample_out (sample_out),
        .run_last   (run_last),
        .errors     (fail_count),
        .pending    (pending)
    );

    // mostly short gaps, now and then a long one
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 45)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [31:0] rand_sample();
        case ($urandom_range(0, 9))
            0: return MAX_SAMPLE;
            1: return MIN_SAMPLE;
            2: return 32'($urandom_range(0, 255)) - 32'd128;
            default: return $urandom();
        endcase
    endfunction

    // called and returns at a falling edge
    task automatic send_sample(input logic [31:0] value);
        int gap;
        gap = idle_len();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        sample_in <= value;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        @(negedge clk);
    endtask

    // hold off until every expected beat is out, then let a silent item finish
    task automatic settle();
        in_valid <= 1'b0;
        while (pending != 0)
        begin
            @(negedge clk);
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic set_rates(input logic [2:0] src, input logic [2:0] tgt);
        cfg_we <= 1'b1;
        cfg_index <= lir_pkg::CFG_SOURCE_RATE;
        cfg_data <= src;
        @(negedge clk);
        cfg_index <= lir_pkg::CFG_TARGET_RATE;
        cfg_data <= tgt;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial
    begin
        int stall_len;
        int free_len;
        out_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall_len = idle_len();
            if (stall_len > 0)
            begin
                @(negedge clk);
                out_stall <= 1'b1;
                repeat (stall_len - 1) @(negedge clk);
            end
            free_len = $urandom_range(1, 6);
            @(negedge clk);
            out_stall <= 1'b0;
            repeat (free_len - 1) @(negedge clk);
        end
    end

    initial
    begin
        int sent;
        int run_len;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = lir_pkg::CFG_SOURCE_RATE;
        cfg_data = '0;
        in_valid = 1'b0;
        sample_in = '0;
        no_idle = 1'b0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // first sample only primes, then a small upsample with full-scale swings
        set_rates(RATE_44100, RATE_48000);
        send_sample(MAX_SAMPLE);
        send_sample(MIN_SAMPLE);
        send_sample(MAX_SAMPLE);
        send_sample(32'd0);
        settle();
        set_rates(RATE_48000, RATE_48000);
        send_sample(MIN_SAMPLE);
        send_sample(MAX_SAMPLE);
        settle();
        // three beats per sample
        set_rates(RATE_16000, RATE_48000);
        send_sample(MIN_SAMPLE);
        send_sample(MAX_SAMPLE);
        send_sample(32'hffff_ffff);
        send_sample(32'd1);
        settle();
        // downsample by three: most samples give nothing
        set_rates(RATE_48000, RATE_16000);
        send_sample(32'h1234_5678);
        send_sample(MIN_SAMPLE);
        send_sample(MAX_SAMPLE);
        send_sample(32'hedcb_a988);
        send_sample(32'd0);
        send_sample(MAX_SAMPLE);
        settle();
        // selects above five saturate
        set_rates(RATE_SAT_B, RATE_SAT_A);
        send_sample(32'h5555_5555);
        send_sample(32'haaaa_aaaa);
        settle();
        set_rates(RATE_SAT_A, RATE_48000);
        send_sample(MAX_SAMPLE);
        send_sample(MIN_SAMPLE);
        send_sample(32'h0000_00ff);
        settle();
        set_rates(RATE_44100, RATE_16000);
        send_sample(MIN_SAMPLE);
        send_sample(MAX_SAMPLE);
        send_sample(32'h8000_0001);
        settle();
        set_rates(RATE_32000, RATE_44100);

        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            no_idle = ($urandom_range(0, 4) == 0);
            run_len = $urandom_range(4, 40);
            if (run_len > RANDOM_ITEMS - sent)
                run_len = RANDOM_ITEMS - sent;
            repeat (run_len)
            begin
                send_sample(rand_sample());
                sent++;
            end
            settle();
            set_rates(3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)));
        end
        no_idle = 1'b0;
        send_sample(rand_sample());
        send_sample(rand_sample());
        settle();

        if (fail_count == 0 && pending == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
